@@ hw/rtl/ppdec_pkg.sv @@
package ppdec_pkg;

   localparam int DEFAULT_MAX_VALUE_BYTES  = 512;
   localparam int DEFAULT_MAX_PREFIX_CHARS = 24;

   // register file layout
   localparam int PREFIX_CHAR_SLOTS = 24;
   localparam int PREFIX_LEN_W      = 5;
   localparam int LIMIT_W           = 10;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_INDEX_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_0_7    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_8_15   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_16_23  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_LIMIT   = 3'd4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

   // characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   // result kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [PREFIX_CHAR_SLOTS-1:0][7:0] prefix;
      logic [PREFIX_LEN_W-1:0]           match_len;
      logic [LIMIT_W-1:0]                limit;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef enum logic [5:0] {
      PH_BETWEEN    = 6'b000001,
      PH_PREFIX     = 6'b000010,
      PH_DIGITS     = 6'b000100,
      PH_VALUE      = 6'b001000,
      PH_SKIP_TOKEN = 6'b010000,
      PH_SKIP_LINE  = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      ESC_NONE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_type;

endpackage

@@ hw/rtl/ppdec_csr.sv @@
module ppdec_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ppdec_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ppdec_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ppdec_pkg::cfg_type                 cfg
);
   import ppdec_pkg::*;

   logic [CSR_DATA_W-1:0]   prefix0_ff, prefix1_ff, prefix2_ff;
   logic [CSR_DATA_W-1:0]   prefix0_in, prefix1_in, prefix2_in;
   logic [PREFIX_LEN_W-1:0] plen_ff, plen_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;

   always_comb begin
      prefix0_in = prefix0_ff;
      prefix1_in = prefix1_ff;
      prefix2_in = prefix2_ff;
      plen_in    = plen_ff;
      limit_in   = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PREFIX_0_7:    prefix0_in = csr_wdata;
            CSR_PREFIX_8_15:   prefix1_in = csr_wdata;
            CSR_PREFIX_16_23:  prefix2_in = csr_wdata;
            CSR_PREFIX_LENGTH: plen_in    = csr_wdata[PREFIX_LEN_W-1:0];
            CSR_VALUE_LIMIT:   limit_in   = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix0_ff <= '0;
         prefix1_ff <= '0;
         prefix2_ff <= '0;
         plen_ff    <= '0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         prefix0_ff <= prefix0_in;
         prefix1_ff <= prefix1_in;
         prefix2_ff <= prefix2_in;
         plen_ff    <= plen_in;
         limit_ff   <= limit_in;
      end
   end

   assign cfg.prefix    = {prefix2_ff, prefix1_ff, prefix0_ff};
   assign cfg.match_len = plen_ff;
   assign cfg.limit     = limit_ff;

endmodule

@@ hw/rtl/ppdec_core.sv @@
module ppdec_core #(
   parameter int MAX_VALUE_BYTES  = ppdec_pkg::DEFAULT_MAX_VALUE_BYTES,
   parameter int MAX_PREFIX_CHARS = ppdec_pkg::DEFAULT_MAX_PREFIX_CHARS
) (
   input  logic                clock,
   input  logic                reset,
   input  ppdec_pkg::cfg_type  cfg,
   input  logic                in_accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output ppdec_pkg::push_type push
);
   import ppdec_pkg::*;

   localparam int CNT_W  = $clog2(MAX_VALUE_BYTES);
   localparam int CMP_W  = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
   localparam int PPOS_W = $clog2(MAX_PREFIX_CHARS + 1);

   phase_type         phase_ff, phase_in;
   esc_type           esc_ff, esc_in;
   logic [PPOS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [3:0]        hi_ff, hi_in;

   logic [PREFIX_LEN_W-1:0] plen_eff;
   logic [CMP_W-1:0]        lim_eff;

   logic              e0_v, e1_v;
   logic [KIND_W-1:0] kind0, kind1;
   logic [7:0]        data0;

   // {valid, value} of a hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
      logic [4:0] r;
      r = '0;
      if (ch inside {[CH_ZERO:CH_NINE]}) begin
         r = {1'b1, ch[3:0]};
      end else if (ch inside {[CH_UPPER_A:CH_UPPER_F], [CH_LOWER_A:CH_LOWER_F]}) begin
         r = {1'b1, 4'(ch[3:0] + 4'd9)};
      end
      return r;
   endfunction

   assign plen_eff = (cfg.match_len > PREFIX_LEN_W'(MAX_PREFIX_CHARS)) ?
                     PREFIX_LEN_W'(MAX_PREFIX_CHARS) : cfg.match_len;
   assign lim_eff  = (CMP_W'(cfg.limit) > CMP_W'(MAX_VALUE_BYTES)) ?
                     CMP_W'(MAX_VALUE_BYTES) : CMP_W'(cfg.limit);

   always_comb begin
      logic       consumed;
      logic       take;
      logic       is_sep;
      logic [4:0] hv;
      logic [7:0] dec;

      phase_in = phase_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      e0_v     = 1'b0;
      e1_v     = 1'b0;
      kind0    = KIND_OK;
      kind1    = KIND_OK;
      data0    = '0;
      consumed = 1'b0;
      take     = 1'b0;
      is_sep   = (in_byte == CH_SPACE) || (in_byte == CH_LF) || (in_byte == CH_TAB);
      hv       = hex_nibble(in_byte);
      dec      = (esc_ff == ESC_NONE) ? in_byte : {hi_ff, hv[3:0]};

      if (phase_in != PH_SKIP_LINE) begin
         if (in_byte == CH_NUL || is_sep) begin
            // token ends here
            if (phase_in == PH_VALUE) begin
               e0_v = 1'b1;
               if (esc_in != ESC_NONE) begin
                  kind0    = KIND_FAIL;
                  phase_in = PH_SKIP_LINE;
               end else begin
                  kind0    = KIND_OK;
                  phase_in = PH_BETWEEN;
               end
            end else begin
               phase_in = PH_BETWEEN;
            end
            esc_in = ESC_NONE;
            if (in_byte == CH_NUL) begin
               phase_in = PH_SKIP_LINE;
            end
         end else begin
            if (phase_in == PH_BETWEEN) begin
               phase_in = PH_PREFIX;
               pos_in   = '0;
            end
            if (phase_in == PH_PREFIX) begin
               if (PREFIX_LEN_W'(pos_in) < plen_eff) begin
                  consumed = 1'b1;
                  if (in_byte == cfg.prefix[PREFIX_LEN_W'(pos_in)]) begin
                     pos_in = pos_in + 1'b1;
                  end else begin
                     phase_in = PH_SKIP_TOKEN;
                  end
               end else begin
                  phase_in = PH_DIGITS;
               end
            end
            if (phase_in == PH_DIGITS && !consumed) begin
               consumed = 1'b1;
               if (in_byte == CH_EQUAL) begin
                  phase_in = PH_VALUE;
                  cnt_in   = '0;
                  esc_in   = ESC_NONE;
                  hi_in    = '0;
               end else if (!(in_byte inside {[CH_ZERO:CH_NINE]})) begin
                  phase_in = PH_SKIP_TOKEN;
               end
            end else if (phase_in == PH_VALUE && !consumed) begin
               if (esc_in == ESC_NONE) begin
                  if (CMP_W'(cnt_in) + 1'b1 >= lim_eff) begin
                     e0_v     = 1'b1;
                     kind0    = KIND_FAIL;
                     phase_in = PH_SKIP_LINE;
                  end else if (in_byte == CH_PERCENT) begin
                     esc_in = ESC_HIGH;
                  end else begin
                     take = 1'b1;
                  end
               end else if (!hv[4]) begin
                  e0_v     = 1'b1;
                  kind0    = KIND_FAIL;
                  esc_in   = ESC_NONE;
                  phase_in = PH_SKIP_LINE;
               end else if (esc_in == ESC_HIGH) begin
                  hi_in  = hv[3:0];
                  esc_in = ESC_LOW;
               end else begin
                  esc_in = ESC_NONE;
                  take   = 1'b1;
               end
               if (take) begin
                  e0_v = 1'b1;
                  if (dec == CH_NUL || dec == CH_LF || dec == CH_CR) begin
                     kind0    = KIND_FAIL;
                     phase_in = PH_SKIP_LINE;
                  end else begin
                     kind0  = KIND_BYTE;
                     data0  = dec;
                     cnt_in = cnt_in + 1'b1;
                  end
               end
            end
         end
      end

      // line end closes an open value
      if (in_last) begin
         if (phase_in == PH_VALUE) begin
            e1_v  = 1'b1;
            kind1 = (esc_in != ESC_NONE) ? KIND_FAIL : KIND_OK;
         end
         phase_in = PH_BETWEEN;
         pos_in   = '0;
         esc_in   = ESC_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         esc_ff   <= ESC_NONE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         hi_ff    <= '0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         hi_ff    <= hi_in;
      end
   end

   always_comb begin
      push.valid0     = in_accept && (e0_v || e1_v);
      push.valid1     = in_accept && e0_v && e1_v;
      push.item1.kind = kind1;
      push.item1.data = '0;
      push.item1.last = 1'b1;
      if (e0_v) begin
         push.item0.kind = kind0;
         push.item0.data = data0;
         push.item0.last = !e1_v;
      end else begin
         push.item0 = push.item1;
      end
   end

`ifndef ASSERT_OFF
   a_line_end_restarts: assert property (@(posedge clock) disable iff (reset)
      in_accept && in_last |=> phase_ff == PH_BETWEEN)
      else $error("scan not restarted after line end");

   a_escape_in_value: assert property (@(posedge clock) disable iff (reset)
      esc_ff != ESC_NONE |-> phase_ff == PH_VALUE)
      else $error("escape pending outside a value");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("scan phase not one-hot");
`endif

endmodule

@@ hw/rtl/ppdec_queue.sv @@
module ppdec_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ppdec_pkg::push_type     push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ppdec_pkg::rsp_item_type out_item
);
   import ppdec_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wp_next;

   assign pop       = out_valid && out_ready;
   assign wp_next   = wp_ff + 1'b1;
   assign room      = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[rp_ff];

   always_comb begin
      wp_in    = wp_ff + PTR_W'(push.valid0) + PTR_W'(push.valid1);
      rp_in    = rp_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.valid0) + CNT_W'(push.valid1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         slot_ff[wp_ff] <= push.item0;
      end
      if (push.valid1) begin
         slot_ff[wp_next] <= push.item1;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.valid0 |-> room)
      else $error("push without room for two results");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0 && !push.item0.last && push.item1.last)
      else $error("second result pushed without a first");
`endif

endmodule

@@ hw/rtl/prefixed_param_percent_decoder.sv @@
// Scans a command line one byte per transfer and percent-decodes the values of tokens of
// the form <prefix><digits>=<value>. Each decoded byte comes out as its own transfer
// (tuser = byte kind), and each value closes with an ok or failed status transfer; rsp_tlast
// marks the last result caused by one input byte. A byte is taken while req_tready is high,
// and its results are registered into the result queue. One byte per clock is sustained
// while the queue has room; a byte that causes two results (a value byte on the marked
// line end) pushes both at once into a four-entry result queue that holds back req_tready
// only when fewer than two entries are free. Configuration registers are written through
// csr_we/csr_index/csr_wdata; doing so only while idle is up to the user, not enforced.
module prefixed_param_percent_decoder #(
   parameter int MAX_VALUE_BYTES  = ppdec_pkg::DEFAULT_MAX_VALUE_BYTES,
   parameter int MAX_PREFIX_CHARS = ppdec_pkg::DEFAULT_MAX_PREFIX_CHARS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // line_byte
   input  logic                              req_tlast,   // line_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // decoded_byte
   output logic [ppdec_pkg::KIND_W-1:0]      rsp_tuser,   // item_kind
   output logic                              rsp_tlast,   // last_of_run
   input  logic                              csr_we,
   input  logic [ppdec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppdec_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ppdec_pkg::*;

   cfg_type      cfg;
   push_type     push;
   rsp_item_type head;
   logic         in_accept;

   assign in_accept = req_tvalid && req_tready;

   ppdec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppdec_core #(
      .MAX_VALUE_BYTES  (MAX_VALUE_BYTES),
      .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .push      (push)
   );

   ppdec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = head.data;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import ppdec_pkg::*;

   // one line byte plus, for hand-checked rows, the results it must cause
   typedef struct packed {
      logic [7:0]        c;
      logic              eol;
      int                n;      // -1: take the predictor's results
      logic [KIND_W-1:0] k0;
      logic [7:0]        d0;
      logic [KIND_W-1:0] k1;
      logic [7:0]        d1;
   } line_item_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;    // line_byte
   logic                   req_tlast;    // line_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;    // decoded_byte
   logic [KIND_W-1:0]      rsp_tuser;    // item_kind
   logic                   rsp_tlast;    // last_of_run
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   prefixed_param_percent_decoder dut (.*);

   // predictor state and registers
   logic [63:0]         pfx_reg [3];
   logic [PREFIX_LEN_W-1:0] pfx_len;
   logic [LIMIT_W-1:0]  val_limit;
   phase_type           scan_ph;
   int                  pfx_pos;
   int                  dec_count;
   esc_type             esc;
   logic [3:0]          hi_nib;
   rsp_item_type        step_out[$];

   rsp_item_type        expected_results[$];
   line_item_type       pending_bytes[$];
   int                  err_count = 0;
   int                  gap_max = 6;

   line_item_type dir_rows [27] = '{
      '{CH_NINE,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{8'h41,      1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_PERCENT, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{8'h34,      1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_LOWER_F, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_PERCENT, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_UPPER_F, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_UPPER_F, 1'b0,  1, KIND_BYTE, 8'hFF, KIND_BYTE, 8'h00},
      '{8'hFF,      1'b0,  1, KIND_BYTE, 8'hFF, KIND_BYTE, 8'h00},
      '{CH_TAB,     1'b0,  1, KIND_OK,   8'h00, KIND_BYTE, 8'h00},
      // empty value closed by a newline
      '{CH_EQUAL,   1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_LF,      1'b0,  1, KIND_OK,   8'h00, KIND_BYTE, 8'h00},
      // bad hex digit
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_PERCENT, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{8'h67,      1'b1,  1, KIND_FAIL, 8'h00, KIND_BYTE, 8'h00},
      // escape decoding to nul
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_PERCENT, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_ZERO,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_ZERO,    1'b1,  1, KIND_FAIL, 8'h00, KIND_BYTE, 8'h00},
      // raw nul closes the value, rest of line ignored
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_NUL,     1'b0,  1, KIND_OK,   8'h00, KIND_BYTE, 8'h00},
      '{8'h71,      1'b1,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      // value byte on the line end gives byte plus status
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{8'h7A,      1'b1,  2, KIND_BYTE, 8'h7A, KIND_OK,   8'h00},
      // escape still open at the line end
      '{CH_EQUAL,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00},
      '{CH_PERCENT, 1'b1,  1, KIND_FAIL, 8'h00, KIND_BYTE, 8'h00}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic bit is_sep(logic [7:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_TAB;
   endfunction

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic void note_result(logic [KIND_W-1:0] k, logic [7:0] d);
      rsp_item_type r;
      if (step_out.size() < 2) begin
         r.kind = k;
         r.data = d;
         r.last = 1'b0;
         step_out.push_back(r);
      end
   endfunction

   function automatic void value_failed();
      note_result(KIND_FAIL, 8'h00);
      esc = ESC_NONE;
      scan_ph = PH_SKIP_LINE;
   endfunction

   function automatic void close_token();
      if (scan_ph == PH_VALUE) begin
         if (esc != ESC_NONE) begin
            value_failed();
            return;
         end
         note_result(KIND_OK, 8'h00);
      end
      if (scan_ph != PH_SKIP_LINE) scan_ph = PH_BETWEEN;
      esc = ESC_NONE;
   endfunction

   function automatic void take_decoded(logic [7:0] v);
      if (v == CH_NUL || v == CH_LF || v == CH_CR) begin
         value_failed();
         return;
      end
      note_result(KIND_BYTE, v);
      dec_count++;
   endfunction

   function automatic void value_char(logic [7:0] c);
      int lim;
      int h;
      lim = (val_limit > DEFAULT_MAX_VALUE_BYTES) ? DEFAULT_MAX_VALUE_BYTES : int'(val_limit);
      if (esc == ESC_NONE) begin
         // room check happens at the start of every source character outside an escape
         if (dec_count + 1 >= lim) begin
            value_failed();
            return;
         end
         if (c == CH_PERCENT) begin
            esc = ESC_HIGH;
            return;
         end
         take_decoded(c);
         return;
      end
      h = hex_nibble(c);
      if (h < 0) begin
         value_failed();
         return;
      end
      if (esc == ESC_HIGH) begin
         hi_nib = h[3:0];
         esc = ESC_LOW;
         return;
      end
      esc = ESC_NONE;
      take_decoded({hi_nib, h[3:0]});
   endfunction

   function automatic void token_char(logic [7:0] c);
      int plen;
      plen = (pfx_len > DEFAULT_MAX_PREFIX_CHARS) ? DEFAULT_MAX_PREFIX_CHARS : int'(pfx_len);
      if (scan_ph == PH_BETWEEN) begin
         scan_ph = PH_PREFIX;
         pfx_pos = 0;
      end
      if (scan_ph == PH_PREFIX) begin
         if (pfx_pos < plen) begin
            if (c == pfx_reg[pfx_pos / 8][(pfx_pos % 8) * 8 +: 8]) pfx_pos++;
            else scan_ph = PH_SKIP_TOKEN;
            return;
         end
         scan_ph = PH_DIGITS;
      end
      if (scan_ph == PH_DIGITS) begin
         if (c >= CH_ZERO && c <= CH_NINE) return;
         if (c == CH_EQUAL) begin
            scan_ph = PH_VALUE;
            dec_count = 0;
            esc = ESC_NONE;
            hi_nib = 4'h0;
         end else begin
            scan_ph = PH_SKIP_TOKEN;
         end
         return;
      end
      if (scan_ph == PH_VALUE) value_char(c);
   endfunction

   // results caused by one line byte, left in step_out
   function automatic void decode_byte(logic [7:0] c, logic eol);
      step_out.delete();
      if (scan_ph != PH_SKIP_LINE) begin
         if (c == CH_NUL) begin
            close_token();
            scan_ph = PH_SKIP_LINE;
         end else if (is_sep(c)) begin
            close_token();
         end else begin
            token_char(c);
         end
      end
      if (eol) begin
         if (scan_ph != PH_SKIP_LINE) close_token();
         scan_ph = PH_BETWEEN;
         pfx_pos = 0;
         esc = ESC_NONE;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [7:0] nonsep_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (is_sep(c));
      return c;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = nonsep_char(); while (c == CH_PERCENT || c == CH_CR);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = nonsep_char(); while (hex_nibble(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return CH_ZERO + 8'(n);
      return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 2))
         0: return CH_SPACE;
         1: return CH_TAB;
         default: return CH_LF;
      endcase
   endfunction

   // prefix, digits, '=' and a value; now and then slightly broken
   function automatic int add_good_token(ref logic [7:0] bytes[$]);
      int peff, lim, bad_at, vlen, r, start;
      logic [7:0] c, v;
      start = bytes.size();
      peff = (pfx_len > DEFAULT_MAX_PREFIX_CHARS) ? DEFAULT_MAX_PREFIX_CHARS : int'(pfx_len);
      lim = (val_limit > DEFAULT_MAX_VALUE_BYTES) ? DEFAULT_MAX_VALUE_BYTES : int'(val_limit);
      bad_at = ($urandom_range(0, 9) == 0 && peff > 0) ? $urandom_range(0, peff - 1) : -1;
      for (int i = 0; i < peff; i++) begin
         c = pfx_reg[i / 8][(i % 8) * 8 +: 8];
         if (i == bad_at) c = c ^ (8'h01 << $urandom_range(0, 7));
         bytes.push_back(c);
      end
      repeat ($urandom_range(0, 3)) bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      bytes.push_back(($urandom_range(0, 19) == 0) ? non_hex_char() : CH_EQUAL);
      // mostly short values, sometimes right at the room boundary
      if ($urandom_range(0, (lim > 64) ? 40 : 6) == 0) vlen = lim - 1 + $urandom_range(0, 2);
      else vlen = $urandom_range(0, 10);
      if (vlen < 0) vlen = 0;
      for (int i = 0; i < vlen; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            bytes.push_back(CH_CR);
         end else if (r < 60) begin
            bytes.push_back(plain_char());
         end else if (r < 92) begin
            if (r < 64) begin
               case ($urandom_range(0, 2))
                  0: v = CH_NUL;
                  1: v = CH_LF;
                  default: v = CH_CR;
               endcase
            end else begin
               v = 8'($urandom_range(0, 255));
            end
            bytes.push_back(CH_PERCENT);
            bytes.push_back(hex_char(v[7:4]));
            bytes.push_back(hex_char(v[3:0]));
         end else begin
            bytes.push_back(CH_PERCENT);
            if (r < 96) bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            bytes.push_back(non_hex_char());
         end
      end
      // escape cut short by the end of the token
      if ($urandom_range(0, 14) == 0) begin
         bytes.push_back(CH_PERCENT);
         if ($urandom_range(0, 1)) bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      return bytes.size() - start;
   endfunction

   // queues one line; returns how many bytes its prefixed tokens hold
   function automatic int add_line();
      logic [7:0] bytes[$];
      line_item_type it;
      int ntok, counted;
      counted = 0;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         ntok = $urandom_range(1, 4);
         for (int t = 0; t < ntok; t++) begin
            if (t > 0 || $urandom_range(0, 3) == 0) bytes.push_back(sep_char());
            if ($urandom_range(0, 9) < 7) begin
               counted += add_good_token(bytes);
            end else begin
               repeat ($urandom_range(1, 8)) bytes.push_back(nonsep_char());
            end
         end
         if ($urandom_range(0, 2) == 0) bytes.push_back(sep_char());
         if ($urandom_range(0, 15) == 0) bytes.insert($urandom_range(0, bytes.size()), CH_NUL);
      end
      it = '0;
      it.n = -1;
      foreach (bytes[i]) begin
         it.c = bytes[i];
         it.eol = (i == bytes.size() - 1);
         pending_bytes.push_back(it);
      end
      return counted;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PREFIX_0_7:    pfx_reg[0] = val;
         CSR_PREFIX_8_15:   pfx_reg[1] = val;
         CSR_PREFIX_16_23:  pfx_reg[2] = val;
         CSR_PREFIX_LENGTH: pfx_len = val[PREFIX_LEN_W-1:0];
         CSR_VALUE_LIMIT:   val_limit = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int plen, input int lim, input bit sep_in_prefix);
      logic [63:0] w [3];
      logic [63:0] v;
      int peff, k;
      for (int r = 0; r < 3; r++)
         for (int b = 0; b < 8; b++) w[r][b * 8 +: 8] = nonsep_char();
      peff = (plen > DEFAULT_MAX_PREFIX_CHARS) ? DEFAULT_MAX_PREFIX_CHARS : plen;
      if (sep_in_prefix && peff > 0) begin
         k = $urandom_range(0, peff - 1);
         w[k / 8][(k % 8) * 8 +: 8] = sep_char();
      end
      write_reg(CSR_PREFIX_0_7, w[0]);
      write_reg(CSR_PREFIX_8_15, w[1]);
      write_reg(CSR_PREFIX_16_23, w[2]);
      // unused upper bits carry junk
      v = {$urandom, $urandom};
      v[PREFIX_LEN_W-1:0] = PREFIX_LEN_W'(plen);
      write_reg(CSR_PREFIX_LENGTH, v);
      v = {$urandom, $urandom};
      v[LIMIT_W-1:0] = LIMIT_W'(lim);
      write_reg(CSR_VALUE_LIMIT, v);
   endtask

   // drives pending_bytes in bursts; the predictor runs on every accepted transfer
   task automatic send_bytes();
      line_item_type cur;
      rsp_item_type typed;
      bit holding;
      int burst_left, gap_left;
      holding = 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
      while (pending_bytes.size() > 0 || holding) begin
         @(posedge clock);
         if (holding && req_tready) begin
            decode_byte(cur.c, cur.eol);
            if (cur.n < 0) begin
               foreach (step_out[i]) expected_results.push_back(step_out[i]);
            end else begin
               if (cur.n >= 1) begin
                  typed.kind = cur.k0;
                  typed.data = cur.d0;
                  typed.last = (cur.n == 1);
                  expected_results.push_back(typed);
               end
               if (cur.n == 2) begin
                  typed.kind = cur.k1;
                  typed.data = cur.d1;
                  typed.last = 1'b1;
                  expected_results.push_back(typed);
               end
            end
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0 || pending_bytes.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               cur = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= cur.c;
               req_tlast <= cur.eol;
               holding = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = $urandom_range(0, gap_max);
               end
            end
         end
      end
   endtask

   // bytes with no result may still be in the pipe when the queue runs dry
   task automatic wait_drained();
      int spins;
      spins = 0;
      while (expected_results.size() > 0 && spins < 50000) begin
         @(posedge clock);
         spins++;
      end
      repeat (8) @(posedge clock);
   endtask

   // receiver stall pattern; the mask is reshuffled periodically
   logic [15:0] stall_mask = '1;
   int          rsp_cycle = 0;
   always @(posedge clock) begin
      if (rsp_cycle % 300 == 0) begin
         if ($urandom_range(0, 2) == 0) stall_mask = '1;
         else stall_mask = 16'($urandom_range(1, 16'hFFFF));
      end
      rsp_tready <= stall_mask[rsp_cycle % 16];
      rsp_cycle++;
   end

   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transfer: item_kind %0d decoded_byte %h last_of_run %b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("item_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata !== want.data) begin
               $error("decoded_byte: expected %h, got %h", want.data, rsp_tdata);
               err_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   initial begin
      int counted;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_PREFIX_0_7;
      csr_wdata <= '0;
      pfx_reg[0] = '0;
      pfx_reg[1] = '0;
      pfx_reg[2] = '0;
      pfx_len = '0;
      val_limit = LIMIT_RESET;
      scan_ph = PH_BETWEEN;
      pfx_pos = 0;
      dec_count = 0;
      esc = ESC_NONE;
      hi_nib = 4'h0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows run on the reset settings: empty prefix, full room
      foreach (dir_rows[i]) pending_bytes.push_back(dir_rows[i]);
      send_bytes();
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_config(0, 1023, 1'b0);
            1: set_config(24, 0, 1'b0);
            2: set_config(31, 1, 1'b0);
            3: set_config($urandom_range(1, 6), 512, 1'b0);
            4: set_config($urandom_range(1, 6), $urandom_range(2, 24), 1'b0);
            5: set_config($urandom_range(2, 6), $urandom_range(2, 24), 1'b1);
            6: set_config($urandom_range(0, 31), $urandom_range(2, 40), 1'b0);
            default: set_config(1, 2, 1'b0);
         endcase
         gap_max = (p == 3) ? 0 : 6;
         counted = 0;
         while (counted < 130) counted += add_line();
         send_bytes();
         wait_drained();
      end

      if (expected_results.size() > 0) begin
         $error("%0d expected transfers never arrived", expected_results.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
